FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the disc pixel design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising edge, switched off while reset is high.
`define ADP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ADP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ADP_ASSERT(lbl, clk, rst, prop, msg)

`define ADP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: sv/adp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disc pixel package
// Widths, register codes, shared types and helpers for the disc pixel block.
// ----------------------------------------------------------------------------
package adp_pkg;

   localparam int PIX_W        = 8;
   localparam int DIA_W        = 9;
   localparam int CHAN_W       = 8;
   localparam int WORD_W       = 32;
   localparam int REG_IDX_W    = 3;
   localparam int CSR_DATA_W   = 9;
   localparam int MAX_DIAMETER = 256;

   localparam int DIA_CAP_I = (MAX_DIAMETER < (1 << DIA_W) - 1) ? MAX_DIAMETER
                                                                 : (1 << DIA_W) - 1;
   localparam logic [DIA_W-1:0] DIA_CAP = DIA_CAP_I[DIA_W-1:0];

   localparam int HALF_W  = DIA_W - 1;
   localparam int OFS_W   = PIX_W + 1;
   localparam int SQ_W    = 2 * PIX_W + 1;
   localparam int FRAC_W  = 8;
   localparam int ROOT_W  = (SQ_W + 2 * FRAC_W + 1) / 2;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int REM_W   = ROOT_W + 2;
   localparam int DIFF_W  = ROOT_W + 2;

   localparam int COV_HALF  = 256;
   localparam int COV_SHIFT = 9;
   localparam int COV_W     = COV_SHIFT + 1;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_DIAMETER = 3'd0,
      REG_RED      = 3'd1,
      REG_GREEN    = 3'd2,
      REG_BLUE     = 3'd3,
      REG_ALPHA    = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [DIA_W-1:0]  diameter;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } cfg_type;

   // Partial square root travelling along the chain of cells.
   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
   } root_word_type;

   // Centre of the image, with the diameter saturated first.
   function automatic logic [HALF_W-1:0] disc_half(input logic [DIA_W-1:0] dia);
      logic [DIA_W-1:0] dia_c;
      dia_c = (dia > DIA_CAP) ? DIA_CAP : dia;
      return dia_c[DIA_W-1:1];
   endfunction

endpackage

FILE: sv/adp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disc pixel channels
// Valid/ready interfaces for pixel requests, pixel words and register writes.
// ----------------------------------------------------------------------------
interface adp_req_if
   import adp_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_row;
   logic [PIX_W-1:0] pixel_col;

   modport source (output valid, output pixel_row, output pixel_col, input ready);
   modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface adp_rsp_if
   import adp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] pixel_word;

   modport source (output valid, output pixel_word, input ready);
   modport sink   (input valid, input pixel_word, output ready);
endinterface

interface adp_csr_if
   import adp_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [REG_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: sv/adp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disc pixel front stage
// Forms the offsets from the centre and the squared distance of a pixel.
// ----------------------------------------------------------------------------
module adp_front
   import adp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   adp_req_if.sink       req,
   output logic          out_valid,
   input  logic          out_ready,
   output root_word_type out_word
);

   logic                      valid_ff;
   logic                      load;
   logic [HALF_W-1:0]         half;
   logic signed [OFS_W-1:0]   ofs_x;
   logic signed [OFS_W-1:0]   ofs_y;
   logic signed [2*OFS_W-1:0] sq_x;
   logic signed [2*OFS_W-1:0] sq_y;
   logic [SQ_W-1:0]           sq;
   root_word_type             word_in;
   root_word_type             word_ff;

   assign half  = disc_half(cfg.diameter);
   assign ofs_x = $signed({1'b0, req.pixel_col}) - $signed({1'b0, half});
   assign ofs_y = $signed({1'b0, req.pixel_row}) - $signed({1'b0, half});
   assign sq_x  = ofs_x * ofs_x;
   assign sq_y  = ofs_y * ofs_y;
   assign sq    = {1'b0, sq_x[SQ_W-2:0]} + {1'b0, sq_y[SQ_W-2:0]};

   always_comb begin
      word_in.rem  = '0;
      word_in.root = '0;
      word_in.rad  = RAD_W'({sq, {(2*FRAC_W){1'b0}}});
   end

   assign req.ready = !valid_ff || out_ready;
   assign load      = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req.ready) begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

FILE: sv/adp_root_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one bit of the root per word and hands the word to the next cell.
// ----------------------------------------------------------------------------
module adp_root_cell
   import adp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  root_word_type in_word,
   output logic          out_valid,
   input  logic          out_ready,
   output root_word_type out_word
);

   logic          valid_ff;
   root_word_type word_in;
   root_word_type word_ff;

   // Restoring step: bring down two radicand bits and try 4q + 1.
   always_comb begin
      logic [REM_W-1:0] trial;
      logic [REM_W-1:0] test;
      trial = {in_word.rem[REM_W-3:0], in_word.rad[RAD_W-1 -: 2]};
      test  = {in_word.root, 2'b01};
      word_in.rad = {in_word.rad[RAD_W-3:0], 2'b00};
      if (trial >= test) begin
         word_in.rem  = trial - test;
         word_in.root = {in_word.root[ROOT_W-2:0], 1'b1};
      end else begin
         word_in.rem  = trial;
         word_in.root = {in_word.root[ROOT_W-2:0], 1'b0};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

FILE: sv/adp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disc pixel back stage
// Turns the distance into coverage, scales alpha and packs the pixel word.
// ----------------------------------------------------------------------------
module adp_back
   import adp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  root_word_type in_word,
   adp_rsp_if.source     rsp
);

   localparam logic signed [DIFF_W-1:0] COV_LO = DIFF_W'(-COV_HALF);
   localparam logic signed [DIFF_W-1:0] COV_HI = DIFF_W'(COV_HALF);
   localparam logic signed [DIFF_W-1:0] RAD_OFS = DIFF_W'(2 << FRAC_W);

   logic                       valid_ff;
   logic [HALF_W-1:0]          half;
   logic signed [DIFF_W-1:0]   rad_fix;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [DIFF_W-1:0]   diff_c;
   logic signed [DIFF_W-1:0]   cov_sum;
   logic [COV_W-1:0]           cov;
   logic [CHAN_W+COV_W-1:0]    prod;
   logic [WORD_W-1:0]          word_in;
   logic [WORD_W-1:0]          word_ff;

   assign half    = disc_half(cfg.diameter);
   assign rad_fix = $signed(DIFF_W'({half, {FRAC_W{1'b0}}})) - RAD_OFS;
   assign diff    = rad_fix - $signed(DIFF_W'(in_word.root));

   always_comb begin
      if (diff < COV_LO) begin
         diff_c = COV_LO;
      end else if (diff > COV_HI) begin
         diff_c = COV_HI;
      end else begin
         diff_c = diff;
      end
   end

   assign cov_sum = diff_c + COV_HI;
   assign cov     = cov_sum[COV_W-1:0];
   assign prod    = cfg.alpha * cov;
   assign word_in = {cfg.red, cfg.green, cfg.blue, prod[COV_SHIFT +: CHAN_W]};

   assign in_ready = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.pixel_word = word_ff;

endmodule

FILE: sv/antialiased_disc_pixel.sv
`timescale 1ns / 1ps
// Pipeline: an accepted request word passes one front stage for the squared
// distance, one root cell per root bit (17) and one back stage.
// Throughput: one word per cycle if unstalled; a stage holds one word and moves on
// when the stage after it is empty or moving, so bubbles close up under a stall.
// Reset: synchronous, clears every stage's valid flag and loads the registers with
// diameter 16 and all colour codes 255. Register writes are always taken.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Anti-aliased disc pixel
// Returns the packed RGBA word of a filled, anti-aliased disc for one pixel.
// ----------------------------------------------------------------------------
module antialiased_disc_pixel
   import adp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   adp_req_if.sink   req_chan,
   adp_rsp_if.source rsp_chan,
   adp_csr_if.sink   csr_chan
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          cell_valid [0:ROOT_W];
   logic          cell_ready [0:ROOT_W];
   root_word_type cell_word  [0:ROOT_W];

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            REG_DIAMETER: cfg_in.diameter = csr_chan.wdata[DIA_W-1:0];
            REG_RED:      cfg_in.red      = csr_chan.wdata[CHAN_W-1:0];
            REG_GREEN:    cfg_in.green    = csr_chan.wdata[CHAN_W-1:0];
            REG_BLUE:     cfg_in.blue     = csr_chan.wdata[CHAN_W-1:0];
            REG_ALPHA:    cfg_in.alpha    = csr_chan.wdata[CHAN_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.diameter <= DIA_W'(16);
         cfg_ff.red      <= '1;
         cfg_ff.green    <= '1;
         cfg_ff.blue     <= '1;
         cfg_ff.alpha    <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   adp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req       (req_chan),
      .out_valid (cell_valid[0]),
      .out_ready (cell_ready[0]),
      .out_word  (cell_word[0])
   );

   for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
      adp_root_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[k]),
         .in_ready  (cell_ready[k]),
         .in_word   (cell_word[k]),
         .out_valid (cell_valid[k+1]),
         .out_ready (cell_ready[k+1]),
         .out_word  (cell_word[k+1])
      );
   end

   adp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (cell_valid[ROOT_W]),
      .in_ready (cell_ready[ROOT_W]),
      .in_word  (cell_word[ROOT_W]),
      .rsp      (rsp_chan)
   );

   // A finished root leaves a remainder no larger than twice the root.
   `ADP_ASSERT(a_root_rem, clock, reset, cell_valid[ROOT_W] |-> (cell_word[ROOT_W].rem <= {1'b0, cell_word[ROOT_W].root, 1'b0}), "root remainder out of range")
   `ADP_ASSERT(a_req_enters, clock, reset, req_chan.valid && req_chan.ready |=> cell_valid[0], "accepted word missing from front stage")
   `ADP_ASSERT(a_back_free, clock, reset, !rsp_chan.valid |-> cell_ready[ROOT_W], "empty output stage refuses a word")
   `ADP_ASSERT_ALWAYS(a_reset_ready, clock, reset |=> req_chan.ready, "not ready after reset")

endmodule

FILE: dv/tb_antialiased_disc_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-aliased disc pixel testbench
// Drives pixel requests and register writes into the disc pixel block and
// checks every returned pixel word against a local model of the disc
// coverage. A short table of directed cases comes first, then randomised
// phases with varying settings, idling on both channels and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_antialiased_disc_pixel;
   import adp_pkg::*;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int RANDOM_PHASES   = 10;
   localparam int PHASE_PIXELS    = 140;
   localparam int REPORT_LIMIT    = 10;

   // Register indexes past the end of the list; writes to them are dropped.
   localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = REG_IDX_W'(int'(REG_ALPHA) + 1);
   localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = '1;

   typedef struct {
      logic [PIX_W-1:0]  row;
      logic [PIX_W-1:0]  col;
      logic [WORD_W-1:0] word;
   } pixel_due_type;

   typedef struct {
      bit                    is_write;
      logic [REG_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] wdata;
      logic [PIX_W-1:0]      row;
      logic [PIX_W-1:0]      col;
      bit                    has_word;
      logic [WORD_W-1:0]     word;
   } stim_entry_type;

   logic clock;
   logic reset;

   adp_req_if req_bus ();
   adp_rsp_if rsp_bus ();
   adp_csr_if csr_bus ();

   antialiased_disc_pixel DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   cfg_type       disc_cfg;
   pixel_due_type pixel_due_q[$];
   int            fault_count;
   int            cycle_count;
   int            send_idle_pct;
   int            recv_stall_pct;
   bit            hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Pixel word of the disc at one pixel, alpha scaled by coverage in units of 1/512.
   function automatic logic [WORD_W-1:0] disc_pixel_word(input cfg_type cfg,
                                                         input logic [PIX_W-1:0] row,
                                                         input logic [PIX_W-1:0] col);
      int                dia;
      int                half;
      int                radius;
      int                dx;
      int                dy;
      int                diff;
      int                cov;
      longint unsigned   acc;
      longint unsigned   root;
      longint unsigned   probe;
      logic [CHAN_W-1:0] alpha;
      dia = int'(cfg.diameter);
      if (dia > MAX_DIAMETER) dia = MAX_DIAMETER;
      half   = dia / 2;
      radius = half - 2;
      dx     = int'(col) - half;
      dy     = int'(row) - half;
      acc    = longint'(dx * dx + dy * dy) << 16;
      // Integer square root, two bits of the radicand per step.
      root  = 0;
      probe = 64'h1 << 62;
      while (probe > acc) probe = probe >> 2;
      while (probe != 0) begin
         if (acc >= root + probe) begin
            acc  = acc - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      diff = radius * 256 - int'(root);
      if (diff < -COV_HALF) diff = -COV_HALF;
      if (diff > COV_HALF) diff = COV_HALF;
      cov   = COV_HALF + diff;
      alpha = CHAN_W'((int'(cfg.alpha) * cov) >> COV_SHIFT);
      return {cfg.red, cfg.green, cfg.blue, alpha};
   endfunction

   function automatic stim_entry_type pixel_entry(input logic [PIX_W-1:0] row,
                                                  input logic [PIX_W-1:0] col,
                                                  input bit has_word = 1'b0,
                                                  input logic [WORD_W-1:0] word = '0);
      stim_entry_type entry;
      entry          = '{default: '0};
      entry.row      = row;
      entry.col      = col;
      entry.has_word = has_word;
      entry.word     = word;
      return entry;
   endfunction

   function automatic stim_entry_type write_entry(input logic [REG_IDX_W-1:0] index,
                                                  input logic [CSR_DATA_W-1:0] wdata);
      stim_entry_type entry;
      entry          = '{default: '0};
      entry.is_write = 1'b1;
      entry.index    = index;
      entry.wdata    = wdata;
      return entry;
   endfunction

   // Mostly inside the image or just past its edge, now and then anywhere.
   function automatic logic [PIX_W-1:0] pick_coord(input int dia);
      int span;
      span = (dia > MAX_DIAMETER) ? MAX_DIAMETER : dia;
      span = (span + 1 > 255) ? 255 : span + 1;
      if ($urandom_range(99) < 85) return PIX_W'($urandom_range(span));
      return PIX_W'($urandom_range(255));
   endfunction

   task automatic offer_pixel(input logic [PIX_W-1:0] row, input logic [PIX_W-1:0] col,
                              input bit has_word, input logic [WORD_W-1:0] word);
      pixel_due_type due;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.pixel_row <= row;
      req_bus.pixel_col <= col;
      do @(posedge clock); while (!req_bus.ready);
      due.row  = row;
      due.col  = col;
      due.word = has_word ? word : disc_pixel_word(disc_cfg, row, col);
      pixel_due_q.push_back(due);
   endtask

   // Settings change only once every word in flight has come back.
   task automatic write_register(input logic [REG_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] wdata);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pixel_due_q.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.wdata <= wdata;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         REG_DIAMETER: disc_cfg.diameter = wdata;
         REG_RED:      disc_cfg.red      = wdata[CHAN_W-1:0];
         REG_GREEN:    disc_cfg.green    = wdata[CHAN_W-1:0];
         REG_BLUE:     disc_cfg.blue     = wdata[CHAN_W-1:0];
         REG_ALPHA:    disc_cfg.alpha    = wdata[CHAN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Receiver: random stalls, or a long hold-off counted out here when asked.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_OFF_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_words
      pixel_due_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pixel_due_q.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("unexpected pixel word %08h", rsp_bus.pixel_word);
         end else begin
            due = pixel_due_q.pop_front();
            if (rsp_bus.pixel_word !== due.word) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("pixel row %0d col %0d: expected %08h, got %08h",
                           due.row, due.col, due.word, rsp_bus.pixel_word);
            end
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      stim_entry_type directed_tab[$];
      int             dia;
      int             idle_mode;

      fault_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b0;
      disc_cfg       = '{diameter: 9'd16, red: 8'hFF, green: 8'hFF, blue: 8'hFF,
                         alpha: 8'hFF};
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.pixel_row <= '0;
      req_bus.pixel_col <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= '0;
      csr_bus.wdata     <= '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_tab = '{
         // Reset settings: diameter 16, centre 8, radius 6, opaque white.
         pixel_entry(8'd8, 8'd8, 1'b1, 32'hFFFF_FFFF),
         pixel_entry(8'd0, 8'd0, 1'b1, 32'hFFFF_FF00),
         pixel_entry(8'd255, 8'd255, 1'b1, 32'hFFFF_FF00),
         pixel_entry(8'd8, 8'd14, 1'b1, 32'hFFFF_FF7F),
         pixel_entry(8'd255, 8'd0),
         pixel_entry(8'd0, 8'd255),
         pixel_entry(8'd10, 8'd13),
         write_entry(REG_DIAMETER, 9'd256),
         pixel_entry(8'd128, 8'd128, 1'b1, 32'hFFFF_FFFF),
         pixel_entry(8'd128, 8'd254, 1'b1, 32'hFFFF_FF7F),
         pixel_entry(8'd0, 8'd0),
         pixel_entry(8'd37, 8'd221),
         // A diameter above the maximum is saturated to it.
         write_entry(REG_DIAMETER, 9'd511),
         pixel_entry(8'd128, 8'd254, 1'b1, 32'hFFFF_FF7F),
         pixel_entry(8'd255, 8'd255),
         // Tiny diameters give a negative or zero radius.
         write_entry(REG_DIAMETER, 9'd0),
         pixel_entry(8'd0, 8'd0, 1'b1, 32'hFFFF_FF00),
         write_entry(REG_DIAMETER, 9'd1),
         pixel_entry(8'd0, 8'd1),
         write_entry(REG_DIAMETER, 9'd4),
         pixel_entry(8'd2, 8'd2, 1'b1, 32'hFFFF_FF7F),
         pixel_entry(8'd3, 8'd2),
         write_entry(REG_DIAMETER, 9'd5),
         pixel_entry(8'd2, 8'd3),
         write_entry(REG_DIAMETER, 9'd16),
         write_entry(REG_RED, 9'h000),
         write_entry(REG_GREEN, 9'h000),
         write_entry(REG_BLUE, 9'h000),
         write_entry(REG_ALPHA, 9'h000),
         pixel_entry(8'd8, 8'd8, 1'b1, 32'h0000_0000),
         // The top bit of the write data is dropped by the colour registers.
         write_entry(REG_RED, 9'h1FF),
         write_entry(REG_GREEN, 9'h1AA),
         write_entry(REG_BLUE, 9'h155),
         write_entry(REG_ALPHA, 9'h180),
         pixel_entry(8'd8, 8'd8, 1'b1, 32'hFFAA_5580),
         write_entry(REG_SPARE_FIRST, 9'h000),
         write_entry(REG_SPARE_LAST, 9'h1FF),
         pixel_entry(8'd8, 8'd8, 1'b1, 32'hFFAA_5580),
         pixel_entry(8'd5, 8'd9),
         write_entry(REG_ALPHA, 9'h0FF),
         write_entry(REG_DIAMETER, 9'd9),
         pixel_entry(8'd4, 8'd6),
         pixel_entry(8'd255, 8'd128),
         pixel_entry(8'd6, 8'd7)
      };
      foreach (directed_tab[i]) begin
         if (directed_tab[i].is_write)
            write_register(directed_tab[i].index, directed_tab[i].wdata);
         else
            offer_pixel(directed_tab[i].row, directed_tab[i].col,
                        directed_tab[i].has_word, directed_tab[i].word);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
         if (phase == 0) begin
            dia = MAX_DIAMETER;
         end else if (phase == RANDOM_PHASES - 1) begin
            dia = 1;
         end else begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: dia = $urandom_range(40, 1);
               6, 7:             dia = $urandom_range(256, 41);
               8:                dia = $urandom_range(511, 257);
               default:          dia = $urandom_range(3, 0);
            endcase
         end
         write_register(REG_DIAMETER, CSR_DATA_W'(dia));
         write_register(REG_RED, CSR_DATA_W'($urandom_range(511)));
         write_register(REG_GREEN, CSR_DATA_W'($urandom_range(511)));
         write_register(REG_BLUE, CSR_DATA_W'($urandom_range(511)));
         write_register(REG_ALPHA, CSR_DATA_W'($urandom_range(511)));
         if ($urandom_range(1) == 1)
            write_register(REG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                           CSR_DATA_W'($urandom_range(511)));

         idle_mode = phase % 4;
         case (idle_mode)
            1: send_idle_pct = 60;
            2: recv_stall_pct = 60;
            3: begin
               send_idle_pct  = 14;
               recv_stall_pct = 14;
            end
            default: ;
         endcase
         // Hold the receiver off while words keep coming so the pipeline backs up.
         if (phase == 4) hold_request = 1'b1;

         for (int n = 0; n < PHASE_PIXELS; n++)
            offer_pixel(pick_coord(dia), pick_coord(dia), 1'b0, '0);
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pixel_due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
